FILE: src/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// double_ended_queue assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define DEQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DEQ_ASSERT(label, clk, rst, prop, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int OPCODE_WIDTH   = 3;
  localparam int POS_WIDTH      = 10;
  localparam int STATUS_WIDTH   = 2;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } deq_mem_ctl_t;

endpackage

FILE: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity double-ended queue held in a circular ram
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one operation per transfer:
//   opcode, push_value and position. output channel (out_valid/out_ready)
//   carries exactly one result per operation: read_value, element_count and
//   status, in operation order.
//   a result is valid the cycle after its operation is taken. throughput is
//   one operation per cycle while out_ready is high; the pointer and count
//   update plus one ram access set that figure.
//   read_value comes straight from the ram's registered read port, and is
//   zero unless the operation was a successful read at position.
//   when the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; the ram read data holds with it.
//   reset clears the pointers, the count and the output valid; the ram
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [deq_pkg::OPCODE_WIDTH-1:0]   opcode,
  input  logic [DATA_WIDTH-1:0]              push_value,
  input  logic [deq_pkg::POS_WIDTH-1:0]      position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_WIDTH-1:0]              read_value,
  output logic [$clog2(CAPACITY+1)-1:0]      element_count,
  output logic [deq_pkg::STATUS_WIDTH-1:0]   status
);

  import deq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               accept;
  deq_mem_ctl_t       mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [CNT_W-1:0]   count_after;
  status_t            op_status;
  logic [DATA_WIDTH-1:0] rd_data;

  logic               read_ok;
  logic [CNT_W-1:0]   count_q;
  status_t            status_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  deq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .position    (position),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .count_after (count_after),
    .status      (op_status)
  );

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_addr),
    .wr_data (push_value),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_ok  <= mem_ctl.rd_en;
      count_q  <= count_after;
      status_q <= op_status;
    end
  end

  assign read_value    = read_ok ? rd_data : '0;
  assign element_count = count_q;
  assign status        = status_q;

endmodule

FILE: src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// front and back slot pointers, element count and per-operation decode
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_ctrl #(
  parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [deq_pkg::OPCODE_WIDTH-1:0]   opcode,
  input  logic [deq_pkg::POS_WIDTH-1:0]      position,
  output deq_pkg::deq_mem_ctl_t              mem_ctl,
  output logic [$clog2(CAPACITY)-1:0]        mem_addr,
  output logic [$clog2(CAPACITY+1)-1:0]      count_after,
  output deq_pkg::status_t                   status
);

  import deq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = ((AW > POS_WIDTH) ? AW : POS_WIDTH) + 1;
  localparam logic [AW-1:0]    LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);

  logic [AW-1:0]    front, front_next;
  logic [AW-1:0]    back, back_next;
  logic [CNT_W-1:0] count, count_next;

  logic [AW-1:0]    front_prev, front_inc, back_prev, back_inc;
  logic [SUM_W-1:0] read_sum, read_slot;
  logic             full, empty;

  assign full       = (count == FULL_CNT);
  assign empty      = (count == '0);
  assign front_prev = (front == '0) ? LAST_SLOT : front - AW'(1);
  assign front_inc  = (front == LAST_SLOT) ? '0 : front + AW'(1);
  assign back_prev  = (back == '0) ? LAST_SLOT : back - AW'(1);
  assign back_inc   = (back == LAST_SLOT) ? '0 : back + AW'(1);
  assign read_sum   = SUM_W'(front) + SUM_W'(position);
  assign read_slot  = (read_sum >= CAP_SUM) ? read_sum - CAP_SUM : read_sum;

  always_comb begin
    front_next    = front;
    back_next     = back;
    count_next    = count;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_addr      = back;
    status        = ST_OK;
    case (opcode_t'(opcode))
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_ctl.wr_en = accept;
          mem_addr      = back;
          back_next     = back_inc;
          count_next    = count + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_ctl.wr_en = accept;
          mem_addr      = front_prev;
          front_next    = front_prev;
          count_next    = count + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          back_next  = back_prev;
          count_next = count - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (SUM_W'(position) >= SUM_W'(count)) begin
          status = ST_RANGE;
        end else begin
          mem_ctl.rd_en = accept;
          mem_addr      = read_slot[AW-1:0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign count_after = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  // pointers and count stay consistent: front plus count wraps onto back
  logic [SUM_W-1:0] span_sum, span_slot;
  assign span_sum  = SUM_W'(front) + SUM_W'(count);
  assign span_slot = (span_sum >= CAP_SUM) ? span_sum - CAP_SUM : span_sum;

  `DEQ_ASSERT(a_count_bound, clk, rst, count <= FULL_CNT, "count beyond capacity")
  `DEQ_ASSERT(a_span, clk, rst, span_slot[AW-1:0] == back, "front, back and count disagree")
  `DEQ_ASSERT(a_one_port, clk, rst, !(mem_ctl.wr_en && mem_ctl.rd_en), "write and read together")
  `DEQ_ASSERT_NEXT(a_push_grows, clk, rst,
    accept && mem_ctl.wr_en, count == $past(count) + CNT_W'(1), "push did not grow count")
  `DEQ_ASSERT_NEXT(a_refused_holds, clk, rst,
    accept && (status == ST_FULL || status == ST_EMPTY || status == ST_RANGE),
    $stable(count) && $stable(front) && $stable(back), "refused operation changed state")

endmodule
